[design/chte_pkg.sv]
package chte_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned HndW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SumW    = 8;   // digit sum tops out at 150

  typedef enum logic {
    CMD_INSERT   = 1'b0,
    CMD_RETRIEVE = 1'b1
  } command_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_POOL_FULL = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch item, read bucket head
    logic rd_head;  // read node at bucket head
    logic rd_next;  // read node at next link
    logic hit;      // key matched current node
    logic finish;   // commit update, issue result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_vld;
    logic key_match;
    logic next_vld;
  } ctrl_sts_t;

endpackage

[design/chte_ctrl.sv]
module chte_ctrl import chte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_NODE = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_HEAD;
        end
      end
      S_HEAD: begin
        if (sts_i.head_vld) begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_NODE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_NODE: begin
        if (sts_i.key_match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_FIN;
        end else if (sts_i.next_vld) begin
          cmd_o.rd_next = 1'b1;
        end else begin
          state_d = S_FIN;   // end of chain, cur node is the tail
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

[design/chte_dpath.sv]
module chte_dpath import chte_pkg::*; #(
  parameter int unsigned BUCKETS    = 16,
  parameter int unsigned POOL_NODES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_sts_t          sts_o,
  input  logic               command_i,
  input  logic [KeyW-1:0]    customer_id_bcd_i,
  input  logic [HndW-1:0]    record_handle_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [HndW-1:0]    found_handle_o
);

  localparam int unsigned NodeW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned CntW  = $clog2(POOL_NODES + 1);
  localparam int unsigned BktW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned TabN  = 2 ** SumW;

  // ---------------- bucket index ----------------
  logic [3:0]      d0, d1, d2, d3;
  logic [SumW-1:0] dsum;
  logic [BktW-1:0] bkt_tab [TabN];
  logic [BktW-1:0] bkt_in;

  assign d0 = customer_id_bcd_i[15:12];
  assign d1 = customer_id_bcd_i[11:8];
  assign d2 = customer_id_bcd_i[7:4];
  assign d3 = customer_id_bcd_i[3:0];

  // weights 1,2,3,4
  assign dsum = {4'b0, d0}
              + {3'b0, d1, 1'b0}
              + {3'b0, d2, 1'b0} + {4'b0, d2}
              + {2'b0, d3, 2'b0};

  // sum mod BUCKETS as a constant lookup
  for (genvar g = 0; g < TabN; g++) begin : g_tab
    assign bkt_tab[g] = BktW'(g % BUCKETS);
  end

  assign bkt_in = bkt_tab[dsum];

  // ---------------- item registers ----------------
  logic            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [HndW-1:0] hnd_q;
  logic [BktW-1:0] bkt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= command_i;
      key_q <= customer_id_bcd_i;
      hnd_q <= record_handle_i;
      bkt_q <= bkt_in;
    end
  end

  // ---------------- allocation / control regs ----------------
  logic [CntW-1:0]  nf_q;
  logic [NodeW-1:0] nf_idx;
  logic             full;
  logic [BUCKETS-1:0] head_flag_q;
  logic             head_vld_q;
  logic             hit_q;
  logic             append;

  assign nf_idx = nf_q[NodeW-1:0];
  assign full   = (nf_q == CntW'(POOL_NODES));
  assign append = cmd_i.finish && (cmd_q == CMD_INSERT) && !hit_q && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q        <= '0;
      head_flag_q <= '0;
      head_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        head_vld_q <= head_flag_q[bkt_in];
        hit_q      <= 1'b0;
      end
      if (cmd_i.hit) begin
        hit_q <= 1'b1;
      end
      if (append) begin
        nf_q <= nf_q + CntW'(1);
        if (!head_vld_q) begin
          head_flag_q[bkt_q] <= 1'b1;
        end
      end
    end
  end

  // ---------------- bucket head memory ----------------
  logic [NodeW-1:0] head_mem [BUCKETS];
  logic [NodeW-1:0] head_idx_q;

  always_ff @(posedge clk_i) begin
    if (append && !head_vld_q) begin
      head_mem[bkt_q] <= nf_idx;
    end
    if (cmd_i.accept) begin
      head_idx_q <= head_mem[bkt_in];
    end
  end

  // ---------------- node memories ----------------
  logic [KeyW+HndW-1:0] kh_mem [POOL_NODES];
  logic [NodeW:0]       nx_mem [POOL_NODES];   // {valid, index}
  logic [KeyW+HndW-1:0] kh_rd_q;
  logic [NodeW:0]       nx_rd_q;
  logic [NodeW-1:0]     cur_q;
  logic                 node_re;
  logic [NodeW-1:0]     node_ra;
  logic                 nx_we;
  logic [NodeW-1:0]     nx_wa;
  logic [NodeW:0]       nx_wd;

  assign node_re = cmd_i.rd_head || cmd_i.rd_next;
  assign node_ra = cmd_i.rd_head ? head_idx_q : nx_rd_q[NodeW-1:0];

  // the free node's link is cleared early, at accept; it is unreachable then
  assign nx_we = (cmd_i.accept && !full) || (append && head_vld_q);
  assign nx_wa = cmd_i.accept ? nf_idx : cur_q;
  assign nx_wd = cmd_i.accept ? '0 : {1'b1, nf_idx};

  always_ff @(posedge clk_i) begin
    if (append) begin
      kh_mem[nf_idx] <= {key_q, hnd_q};
    end
    if (node_re) begin
      kh_rd_q <= kh_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    if (node_re) begin
      nx_rd_q <= nx_mem[node_ra];
      cur_q   <= node_ra;
    end
  end

  assign sts_o.head_vld  = head_vld_q;
  assign sts_o.key_match = (kh_rd_q[KeyW+HndW-1:HndW] == key_q);
  assign sts_o.next_vld  = nx_rd_q[NodeW];

  // ---------------- result ----------------
  status_e         status_d;
  logic [HndW-1:0] fh_d;
  logic            done_q;
  logic [StatusW-1:0] status_q;
  logic [HndW-1:0] fh_q;

  always_comb begin
    fh_d = '0;
    if (cmd_q == CMD_RETRIEVE) begin
      if (hit_q) begin
        status_d = ST_FOUND;
        fh_d     = kh_rd_q[HndW-1:0];
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end else if (hit_q) begin
      status_d = ST_DUPLICATE;
    end else if (full) begin
      status_d = ST_POOL_FULL;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      fh_q     <= fh_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_handle_o = fh_q;

endmodule

[design/chained_hash_table_engine_core.sv]
// Chained hash table engine.
// Command channel: an item (command_i, customer_id_bcd_i, record_handle_i) is
//   taken at a clock edge with start high and busy low. Insert stores the key
//   with its handle; retrieve looks the key up.
// Result channel: done_o is high for one cycle with status_o and
//   found_handle_o valid. The receiver cannot stall; each item gives one result.
// Walk: an item reads N chain nodes (0 for an empty bucket, up to the chain
//   length). Node memory has one read port and registered read data, so the
//   walk reads one node at a time. done_o rises in the cycle after the commit
//   state, when busy is already low, so the next item may be accepted in the
//   same cycle the result is shown.
// Reset: all buckets empty, node pool empty. No clearing pass is needed;
//   bucket heads carry valid flops and nodes are only read once allocated.
// Nodes are handed out in order and never freed; when the pool is used up a
//   new key answers pool full, while a duplicate still answers duplicate.
module chained_hash_table_engine_core import chte_pkg::*; #(
  parameter int unsigned BUCKETS    = 16,
  parameter int unsigned POOL_NODES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [KeyW-1:0]    customer_id_bcd_i,
  input  logic [HndW-1:0]    record_handle_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [HndW-1:0]    found_handle_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: idle -> head read -> node walk -> commit
  chte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // bucket hash, head table, node pool, result registers
  chte_dpath #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (command_i),
    .customer_id_bcd_i (customer_id_bcd_i),
    .record_handle_i   (record_handle_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .found_handle_o    (found_handle_o)
  );

  // a result never overlaps an item in flight
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // accepted item keeps the engine busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  // single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // handle is only reported on a hit
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_FOUND)) |-> (found_handle_o == '0))
    else $error("nonzero handle without found status");

endmodule
